[rtl/core/msp_pkg.sv]
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and codes for the Morse symbol packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

  // Result kinds
  localparam logic [2:0] KIND_DIT  = 3'd0;
  localparam logic [2:0] KIND_DAH  = 3'd1;
  localparam logic [2:0] KIND_CGAP = 3'd2;
  localparam logic [2:0] KIND_WGAP = 3'd3;
  localparam logic [2:0] KIND_END  = 3'd4;

  // Packet end status
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BADVER = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;

  // Two-bit symbol codes on the wire
  localparam logic [1:0] PAIR_CGAP = 2'b00;
  localparam logic [1:0] PAIR_DIT  = 2'b01;
  localparam logic [1:0] PAIR_DAH  = 2'b10;
  localparam logic [1:0] PAIR_WGAP = 2'b11;

  // Required header version
  localparam logic [1:0] VERSION_OK = 2'b01;

  // Symbols per payload byte
  localparam int unsigned PAIRS_PER_BYTE = 4;

  typedef enum logic [1:0] {
    POS_HEADER,
    POS_SPEED,
    POS_PAYLOAD
  } pos_t;

  function automatic logic [2:0] pair_to_kind(input logic [1:0] pair);
    logic [2:0] kind;
    unique case (pair)
      PAIR_DIT:  kind = KIND_DIT;
      PAIR_DAH:  kind = KIND_DAH;
      PAIR_CGAP: kind = KIND_CGAP;
      default:   kind = KIND_WGAP;
    endcase
    return kind;
  endfunction

endpackage

`default_nettype wire

[rtl/core/morse_symbol_packet_parser_top.sv]
// ----------------------------------------------------------------------------
// morse_symbol_packet_parser_top
// Splits Morse-over-packet bytes into dit/dah/gap symbols and a packet end.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one packet byte per request, with
// last_byte set on the final byte. Output channel (out_valid/out_ready) carries
// one result per request: a symbol, or the packet end with speed and status.
// run_last marks the final result produced by an input byte.
// An accepted byte is decoded in the same cycle into a small result buffer;
// its first result is presented on the next cycle and the rest follow one per
// cycle while out_ready is high. Header bytes other than a last byte give no
// results; rejected and stopped packets give no symbols, only the packet end.
// A byte's results hold the output until all are taken; the next byte is
// accepted in the cycle its last result is taken, so a one-result-per-byte
// stream runs at one byte per cycle while out_ready is high. A stalled
// receiver holds the current result and blocks input until the buffer's last
// result is taken. Synchronous reset restarts at the header byte, buffer empty.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_symbol_packet_parser_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      symbol_kind,
  output logic [5:0]      packet_speed,
  output logic [1:0]      packet_status,
  output logic            run_last
);
  import msp_pkg::*;

  // Parser state
  pos_t       pos, pos_next;
  logic       version_bad, version_bad_next;
  logic       stopped, stopped_next;
  logic [5:0] held_speed, held_speed_next;

  // Result buffer
  logic [2:0] buf_kind [PAIRS_PER_BYTE];
  logic [2:0] buf_nsym;
  logic       buf_end;
  logic [5:0] buf_speed;
  logic [1:0] buf_status;
  logic [2:0] idx;
  logic [2:0] buf_total;

  // Decode of the incoming byte
  logic [1:0] pair   [PAIRS_PER_BYTE];
  logic [2:0] dec_kind [PAIRS_PER_BYTE];
  logic [2:0] dec_nsym;
  logic       dec_wgap;
  logic [5:0] dec_speed;
  logic [1:0] dec_status;
  logic [2:0] dec_total;
  logic       accept, drain_last;

  assign buf_total  = buf_nsym + {2'b00, buf_end};
  assign drain_last = out_valid && out_ready && (idx + 3'd1 == buf_total);
  assign in_ready   = !out_valid || drain_last;
  assign accept     = in_valid && in_ready;

  // Next-state for the byte position
  always_comb begin
    pos_next = pos;
    if (accept) begin
      if (last_byte) begin
        pos_next = POS_HEADER;
      end else begin
        unique case (pos)
          POS_HEADER: pos_next = POS_SPEED;
          POS_SPEED:  pos_next = POS_PAYLOAD;
          default:    pos_next = POS_PAYLOAD;
        endcase
      end
    end
  end

  // Symbol decode and packet-end fields
  always_comb begin
    logic run;
    for (int i = 0; i < PAIRS_PER_BYTE; i++) begin
      pair[i] = data_byte[7 - 2*i -: 2];
    end
    for (int i = 0; i < PAIRS_PER_BYTE; i++) begin
      dec_kind[i] = pair_to_kind(pair[i]);
    end
    dec_nsym   = 3'd0;
    dec_wgap   = 1'b0;
    dec_speed  = 6'd0;
    dec_status = STATUS_OK;
    run        = !version_bad && !stopped;
    unique case (pos)
      POS_HEADER: begin
        dec_status = STATUS_SHORT;
      end
      POS_SPEED: begin
        // only the low pair of the speed byte is a symbol
        dec_kind[0] = pair_to_kind(pair[3]);
        if (run) begin
          dec_nsym = 3'd1;
          dec_wgap = (pair[3] == PAIR_WGAP);
        end
        dec_speed  = version_bad ? 6'd0 : data_byte[7:2];
        dec_status = version_bad ? STATUS_BADVER : STATUS_OK;
      end
      default: begin
        for (int i = 0; i < PAIRS_PER_BYTE; i++) begin
          if (run) begin
            dec_nsym = dec_nsym + 3'd1;
            if (pair[i] == PAIR_WGAP) begin
              run      = 1'b0;
              dec_wgap = 1'b1;
            end
          end
        end
        dec_speed  = version_bad ? 6'd0 : held_speed;
        dec_status = version_bad ? STATUS_BADVER : STATUS_OK;
      end
    endcase
    dec_total = dec_nsym + {2'b00, last_byte};
  end

  // Header and stop state updates, cleared on the last byte
  always_comb begin
    version_bad_next = version_bad;
    stopped_next     = stopped;
    held_speed_next  = held_speed;
    if (accept) begin
      if (last_byte) begin
        version_bad_next = 1'b0;
        stopped_next     = 1'b0;
        held_speed_next  = 6'd0;
      end else begin
        if (pos == POS_HEADER) begin
          version_bad_next = (data_byte[7:6] != VERSION_OK);
        end
        if (pos == POS_SPEED) begin
          held_speed_next = data_byte[7:2];
        end
        stopped_next = stopped || dec_wgap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_HEADER;
      version_bad <= 1'b0;
      stopped     <= 1'b0;
      held_speed  <= 6'd0;
      out_valid   <= 1'b0;
      idx         <= 3'd0;
    end else begin
      pos         <= pos_next;
      version_bad <= version_bad_next;
      stopped     <= stopped_next;
      held_speed  <= held_speed_next;
      if (accept) begin
        out_valid <= (dec_total != 3'd0);
        idx       <= 3'd0;
      end else if (out_valid && out_ready) begin
        if (drain_last) begin
          out_valid <= 1'b0;
        end
        idx <= idx + 3'd1;
      end
    end
  end

  // Buffer payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      buf_kind   <= dec_kind;
      buf_nsym   <= dec_nsym;
      buf_end    <= last_byte;
      buf_speed  <= dec_speed;
      buf_status <= dec_status;
    end
  end

  // Symbols come first, then the packet end
  always_comb begin
    if (idx < buf_nsym) begin
      symbol_kind   = buf_kind[idx[1:0]];
      packet_speed  = 6'd0;
      packet_status = STATUS_OK;
    end else begin
      symbol_kind   = KIND_END;
      packet_speed  = buf_speed;
      packet_status = buf_status;
    end
    run_last = (idx + 3'd1 == buf_total);
  end

endmodule

`default_nettype wire
